@@ src/ssc_pkg.sv @@
package ssc_pkg;

    localparam int SSC_TIMER_WIDTH = 17;
    localparam int SSC_CFG_WIDTH   = 16;
    localparam int SSC_IDX_WIDTH   = 2;
    localparam int SSC_POS_WIDTH   = 3;
    localparam int SSC_GATES       = 6;
    localparam int SSC_IN_BYTES    = 1;
    localparam int SSC_OUT_BYTES   = 2;

    localparam logic [SSC_POS_WIDTH-1:0] SSC_LAST_POS = 3'd5;

    localparam logic [15:0] SSC_STEP_TICKS_RST = 16'd2000;
    localparam logic [15:0] SSC_DEAD_TICKS_RST = 16'd50;

    localparam logic [SSC_IDX_WIDTH-1:0] SSC_REG_REVERSE    = 2'd0;
    localparam logic [SSC_IDX_WIDTH-1:0] SSC_REG_STEP_TICKS = 2'd1;
    localparam logic [SSC_IDX_WIDTH-1:0] SSC_REG_DEAD_TICKS = 2'd2;

    typedef struct packed {
        logic                     reverse_direction;
        logic [SSC_CFG_WIDTH-1:0] step_ticks;
        logic [SSC_CFG_WIDTH-1:0] dead_ticks;
    } t_ssc_cfg;

    // Packed so that the gates sit in the lowest bits.
    typedef struct packed {
        logic                     in_dead_time;
        logic [SSC_POS_WIDTH-1:0] step_number;
        logic [SSC_GATES-1:0]     gates;
    } t_ssc_result;

    localparam int SSC_RESULT_WIDTH = $bits(t_ssc_result);

    // Gate bit order: a_high, a_low, b_high, b_low, c_high, c_low.
    function automatic logic [SSC_GATES-1:0] ssc_high_mask(
        input logic [SSC_POS_WIDTH-1:0] idx
    );
        logic [SSC_GATES-1:0] m;
        case (idx)
            3'd0, 3'd1: m = 6'b000001;
            3'd2, 3'd3: m = 6'b000100;
            3'd4, 3'd5: m = 6'b010000;
            default:    m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [SSC_GATES-1:0] ssc_low_mask(
        input logic [SSC_POS_WIDTH-1:0] idx
    );
        logic [SSC_GATES-1:0] m;
        case (idx)
            3'd0, 3'd5: m = 6'b001000;
            3'd1, 3'd2: m = 6'b100000;
            3'd3, 3'd4: m = 6'b000010;
            default:    m = '0;
        endcase
        return m;
    endfunction

endpackage

@@ src/ssc_cfg.sv @@
module ssc_cfg
    import ssc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [SSC_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [SSC_CFG_WIDTH-1:0] i_cfg_data,
    output t_ssc_cfg                 o_cfg
);

    t_ssc_cfg r_cfg;
    t_ssc_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                SSC_REG_REVERSE:    n_cfg.reverse_direction = i_cfg_data[0];
                SSC_REG_STEP_TICKS: n_cfg.step_ticks        = i_cfg_data;
                SSC_REG_DEAD_TICKS: n_cfg.dead_ticks        = i_cfg_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reverse_direction <= 1'b0;
            r_cfg.step_ticks        <= SSC_STEP_TICKS_RST;
            r_cfg.dead_ticks        <= SSC_DEAD_TICKS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/ssc_core.sv @@
module ssc_core
    import ssc_pkg::*;
#(
    parameter int TIMER_WIDTH = SSC_TIMER_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_advance,
    input  logic        i_run,
    input  t_ssc_cfg    i_cfg,
    output t_ssc_result o_result
);

    localparam int CW = ((TIMER_WIDTH > SSC_CFG_WIDTH) ? TIMER_WIDTH : SSC_CFG_WIDTH) + 1;

    logic [SSC_POS_WIDTH-1:0] r_pos;
    logic [SSC_POS_WIDTH-1:0] n_pos;
    logic [TIMER_WIDTH-1:0]   r_tick;
    logic [TIMER_WIDTH-1:0]   n_tick;

    logic [SSC_POS_WIDTH-1:0] w_idx;
    logic [CW-1:0]            w_tick_ext;
    logic [CW-1:0]            w_total;
    logic                     w_dead;
    logic                     w_step_end;

    assign w_idx      = i_cfg.reverse_direction ? (SSC_LAST_POS - r_pos) : r_pos;
    assign w_tick_ext = CW'(r_tick);
    assign w_total    = CW'(i_cfg.dead_ticks) + CW'(i_cfg.step_ticks);
    assign w_dead     = w_tick_ext < CW'(i_cfg.dead_ticks);
    assign w_step_end = ((w_tick_ext + CW'(1)) >= w_total) || (&r_tick);

    always_comb begin
        o_result = '0;
        if (i_run) begin
            o_result.gates        = ssc_high_mask(w_idx)
                                  | (w_dead ? '0 : ssc_low_mask(w_idx));
            o_result.step_number  = w_idx + 3'd1;
            o_result.in_dead_time = w_dead;
        end
    end

    always_comb begin
        n_pos  = r_pos;
        n_tick = r_tick;
        if (i_advance) begin
            if (!i_run) begin
                n_pos  = '0;
                n_tick = '0;
            end else if (w_step_end) begin
                n_pos  = (r_pos == SSC_LAST_POS) ? '0 : r_pos + 3'd1;
                n_tick = '0;
            end else begin
                n_tick = r_tick + TIMER_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_tick <= '0;
        end else begin
            r_pos  <= n_pos;
            r_tick <= n_tick;
        end
    end

endmodule

@@ src/ssc_out_reg.sv @@
module ssc_out_reg
    import ssc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_ssc_result i_result,
    input  logic        i_ready,
    output logic        o_can_load,
    output logic        o_valid,
    output t_ssc_result o_result
);

    logic        r_valid;
    logic        n_valid;
    t_ssc_result r_result;

    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ src/six_step_commutation_sequencer.sv @@
// Six-step commutation sequencer for a three-phase half-bridge.
// The slave stream carries one tick transaction per microsecond; bit 0 of
// s_axis_tdata is the run flag. Each accepted tick produces exactly one
// master-stream transaction with the six gate drives, the step number and
// the dead-time flag.
// The result of a tick is presented on the master side in the cycle after it
// is accepted. Throughput is one tick per cycle unless the receiver stalls,
// set by the single output register behind the step counter and gate decode.
// When the receiver stalls, the held result stays stable and one more tick is
// not accepted until the register drains; s_axis_tready follows
// m_axis_tready in that case.
// Registers are written through i_cfg_we, i_cfg_index and i_cfg_data: index 0
// is the direction, 1 the step ticks, 2 the dead ticks. Write them only while
// no result is pending.
// Synchronous reset clears the output valid, returns the sequence to its
// first step and loads the register defaults: forward, 2000 step ticks and
// 50 dead ticks.
module six_step_commutation_sequencer
    import ssc_pkg::*;
#(
    parameter int TIMER_WIDTH = SSC_TIMER_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // run
    input  logic [8*SSC_IN_BYTES-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // gate_a_high, gate_a_low, gate_b_high, gate_b_low, gate_c_high,
    // gate_c_low, step_number[2:0], in_dead_time
    output logic [8*SSC_OUT_BYTES-1:0] m_axis_tdata,
    input  logic                      i_cfg_we,
    input  logic [SSC_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [SSC_CFG_WIDTH-1:0]  i_cfg_data
);

    t_ssc_cfg    w_cfg;
    t_ssc_result w_core_result;
    t_ssc_result w_out_result;
    logic        w_accept;
    logic        w_can_load;

    assign s_axis_tready = w_can_load;
    assign w_accept      = s_axis_tvalid && w_can_load;

    ssc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ssc_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_accept),
        .i_run     (s_axis_tdata[0]),
        .i_cfg     (w_cfg),
        .o_result  (w_core_result)
    );

    ssc_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_result   (w_core_result),
        .i_ready    (m_axis_tready),
        .o_can_load (w_can_load),
        .o_valid    (m_axis_tvalid),
        .o_result   (w_out_result)
    );

    assign m_axis_tdata = {(8*SSC_OUT_BYTES-SSC_RESULT_WIDTH)'(0), w_out_result};

    a_stopped_gates_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[8:6] == 3'd0) |-> (m_axis_tdata[9:0] == 10'd0))
        else $error("gates driven while stopped");

    a_dead_no_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[9]
        |-> !m_axis_tdata[1] && !m_axis_tdata[3] && !m_axis_tdata[5])
        else $error("low side gate on during dead time");

    a_one_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[8:6] != 3'd0)
        |-> $onehot({m_axis_tdata[0], m_axis_tdata[2], m_axis_tdata[4]}))
        else $error("running step must drive exactly one high side gate");

    a_stop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tdata[0]
        |=> m_axis_tvalid && (m_axis_tdata == '0))
        else $error("stop tick did not give an all-off result");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register is empty");

endmodule

@@ tb/six_step_commutation_sequencer_tb.sv @@
`timescale 1ns / 100ps

module six_step_commutation_sequencer_tb
    import ssc_pkg::*;
();

    localparam logic [SSC_IDX_WIDTH-1:0] REG_SPARE = 2'd3;
    localparam int unsigned TICK_LIMIT = (1 << SSC_TIMER_WIDTH) - 1;
    // Phase index (0 = A, 1 = B, 2 = C) per step, step 1 in the lowest bits.
    localparam logic [11:0] HIGH_PHASE = {2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};
    localparam logic [11:0] LOW_PHASE  = {2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1};

    class commutation_checker;
        bit                  reverse;
        bit [15:0]           step_len;
        bit [15:0]           dead_len;
        int unsigned         position;
        int unsigned         ticks;
        t_ssc_result         expected_gates[$];
        int                  errors;
        int                  checked;
        string               gate_names[SSC_GATES] = '{"gate_a_high", "gate_a_low",
            "gate_b_high", "gate_b_low", "gate_c_high", "gate_c_low"};

        function new();
            reverse  = 1'b0;
            step_len = SSC_STEP_TICKS_RST;
            dead_len = SSC_DEAD_TICKS_RST;
            position = 0;
            ticks    = 0;
            errors   = 0;
            checked  = 0;
        endfunction

        function void set_reg(logic [SSC_IDX_WIDTH-1:0] idx, logic [15:0] val);
            case (idx)
                SSC_REG_REVERSE:    reverse  = val[0];
                SSC_REG_STEP_TICKS: step_len = val;
                SSC_REG_DEAD_TICKS: dead_len = val;
                default: ;
            endcase
        endfunction

        function void note_tick(bit run);
            t_ssc_result r;
            int unsigned idx;
            int unsigned span;
            bit          dead;
            r = '0;
            if (!run) begin
                position = 0;
                ticks    = 0;
            end else begin
                idx  = reverse ? SSC_LAST_POS - position : position;
                dead = ticks < dead_len;
                r.gates[2 * HIGH_PHASE[2 * idx +: 2]] = 1'b1;
                if (!dead) begin
                    r.gates[2 * LOW_PHASE[2 * idx +: 2] + 1] = 1'b1;
                end
                r.step_number  = SSC_POS_WIDTH'(idx + 1);
                r.in_dead_time = dead;
                span = dead_len + step_len;
                if (ticks + 1 >= span || ticks >= TICK_LIMIT) begin
                    ticks    = 0;
                    position = (position + 1) % 6;
                end else begin
                    ticks = ticks + 1;
                end
            end
            expected_gates.push_back(r);
        endfunction

        function void report(string field, int want, int got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_gates(logic [8*SSC_OUT_BYTES-1:0] data);
            t_ssc_result got;
            t_ssc_result want;
            got = t_ssc_result'(data[SSC_RESULT_WIDTH-1:0]);
            if (expected_gates.size() == 0) begin
                errors++;
                $display("%0t: result %h with no tick pending, expected none", $time, data);
                return;
            end
            want = expected_gates.pop_front();
            checked++;
            for (int g = 0; g < SSC_GATES; g++) begin
                if (got.gates[g] !== want.gates[g]) begin
                    report(gate_names[g], want.gates[g], got.gates[g]);
                end
            end
            if (got.step_number !== want.step_number) begin
                report("step_number", want.step_number, got.step_number);
            end
            if (got.in_dead_time !== want.in_dead_time) begin
                report("in_dead_time", want.in_dead_time, got.in_dead_time);
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [8*SSC_IN_BYTES-1:0]  s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [8*SSC_OUT_BYTES-1:0] m_axis_tdata;
    logic                       i_cfg_we = 1'b0;
    logic [SSC_IDX_WIDTH-1:0]   i_cfg_index = '0;
    logic [SSC_CFG_WIDTH-1:0]   i_cfg_data = '0;

    commutation_checker board = new();
    int src_idle_pct = 29;
    int snk_idle_pct = 51;
    int ticks_sent = 0;
    int settings_used = 0;

    six_step_commutation_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[six_step_commutation_sequencer] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_gates(m_axis_tdata);
        end
    end

    task automatic send_tick(input bit run);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(8*SSC_IN_BYTES-1){1'b0}}, run};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_tick(run);
        ticks_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.expected_gates.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [SSC_IDX_WIDTH-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic configure(input logic [15:0] dir, input logic [15:0] steps,
                             input logic [15:0] dead);
        drain();
        write_reg(SSC_REG_REVERSE, dir);
        write_reg(SSC_REG_STEP_TICKS, steps);
        write_reg(SSC_REG_DEAD_TICKS, dead);
        settings_used++;
    endtask

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return 16'($urandom_range(5));
        end else if (r < 92) begin
            return 16'($urandom_range(40, 6));
        end else if (r < 96) begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(65535));
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_tick(1'b0);
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        configure(16'h0000, 16'h0000, 16'h0000);
        repeat (7) send_tick(1'b1);

        drain();
        write_reg(SSC_REG_REVERSE, 16'hFFFF);
        board.set_reg(SSC_REG_REVERSE, 16'hFFFF);
        repeat (4) send_tick(1'b1);

        configure(16'hFFFE, 16'hFFFF, 16'hFFFF);
        repeat (4) send_tick(1'b1);

        configure(16'h0001, 16'h0001, 16'h0001);
        write_reg(REG_SPARE, 16'hFFFF);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        for (int p = 0; p < 12; p++) begin
            if (p == 4) begin
                src_idle_pct = 51;
                snk_idle_pct = 29;
            end else if (p == 8) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            configure(16'($urandom_range(65535)), pick_length(), pick_length());
            for (int k = 0; k < 77; k++) begin
                send_tick($urandom_range(99) < 92);
            end
        end

        drain();
        $display("Sent %0d ticks and checked %0d results across %0d register settings,",
                 ticks_sent, board.checked, settings_used);
        $display("covering both directions, zero and full-range step and dead times.");
        if (board.errors == 0 && board.expected_gates.size() == 0) begin
            $display("[six_step_commutation_sequencer] OK");
        end else begin
            $display("[six_step_commutation_sequencer] ERROR");
        end
        $finish;
    end

endmodule
